// ===== src/bpa_pkg.sv =====
package bpa_pkg;

	// Default pool geometry.
	localparam int POOL_PAGES_DEF = 4096;
	localparam int TOP_ORDER_DEF  = 10;

	// Fixed field widths of the request and response items.
	localparam int MODE_W  = 2;
	localparam int COUNT_W = 13;
	localparam int BASE_W  = 12;
	// Orders never exceed fifteen, and a rounded count never exceeds thirteen.
	localparam int ORD_W   = 4;

	// Request kinds.
	localparam logic [MODE_W-1:0] MODE_ADD   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd1;
	localparam logic [MODE_W-1:0] MODE_FREE  = 2'd2;

	// Response status codes.
	localparam logic STATUS_DONE    = 1'b0;
	localparam logic STATUS_REFUSED = 1'b1;

	// Result of comparing one stored block head against the current request.
	typedef struct packed {
		logic             overlap;
		logic             cand;
		logic [ORD_W-1:0] ord;
	} scan_hit_t;

	// Smallest order whose block holds n pages.
	function automatic logic [ORD_W-1:0] ceil_order(input logic [COUNT_W-1:0] n);
		logic [COUNT_W-1:0] m;
		logic [ORD_W-1:0]   r;
		m = n - COUNT_W'(1);
		r = '0;
		if (n > COUNT_W'(1)) begin
			for (int i = 0; i < COUNT_W; i++) begin
				if (m[i]) begin
					r = ORD_W'(i + 1);
				end
			end
		end
		return r;
	endfunction

endpackage

// ===== src/bpa_req_if.sv =====
interface bpa_req_if;
	import bpa_pkg::*;

	logic               valid;
	logic               ready;
	logic [MODE_W-1:0]  mode;
	logic [COUNT_W-1:0] page_count;
	logic [BASE_W-1:0]  base_page;

	modport source (output valid, output mode, output page_count, output base_page,
		input ready);
	modport sink (input valid, input mode, input page_count, input base_page,
		output ready);

endinterface

// ===== src/bpa_rsp_if.sv =====
interface bpa_rsp_if;
	import bpa_pkg::*;

	logic               valid;
	logic               ready;
	logic               status;
	logic [BASE_W-1:0]  alloc_base;
	logic [COUNT_W-1:0] free_total;

	modport source (output valid, output status, output alloc_base, output free_total,
		input ready);
	modport sink (input valid, input status, input alloc_base, input free_total,
		output ready);

endinterface

// ===== src/bpa_page_mem.sv =====
module bpa_page_mem #(
	parameter int POOL_PAGES = bpa_pkg::POOL_PAGES_DEF,
	parameter int TOP_ORDER  = bpa_pkg::TOP_ORDER_DEF,
	localparam int AW = $clog2(POOL_PAGES),
	localparam int EW = $clog2(TOP_ORDER + 2)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [EW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [EW-1:0] rdata
);

	// One code per page: zero for no block head, else order plus one.
	logic [EW-1:0] mem_q [POOL_PAGES];
	logic [EW-1:0] rdata_q;

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== src/bpa_scan_unit.sv =====
module bpa_scan_unit #(
	parameter int POOL_PAGES = bpa_pkg::POOL_PAGES_DEF,
	parameter int TOP_ORDER  = bpa_pkg::TOP_ORDER_DEF,
	localparam int AW = $clog2(POOL_PAGES),
	localparam int EW = $clog2(TOP_ORDER + 2),
	localparam int WA = (AW > TOP_ORDER) ? AW : TOP_ORDER,
	localparam int WW = ((WA > bpa_pkg::COUNT_W) ? WA : bpa_pkg::COUNT_W) + 2
) (
	input  logic [AW-1:0]               head_addr,
	input  logic [EW-1:0]               head_code,
	input  logic [WW-1:0]               range_lo,
	input  logic [WW-1:0]               range_hi,
	input  logic [bpa_pkg::ORD_W-1:0]   need,
	output bpa_pkg::scan_hit_t          hit
);
	import bpa_pkg::*;

	logic             live;
	logic [ORD_W-1:0] ord;
	logic [WW-1:0]    h_lo;
	logic [WW-1:0]    h_hi;

	// Decode the stored code into the block's page span.
	assign live = (head_code != '0);
	assign ord  = ORD_W'(head_code - EW'(1));
	assign h_lo = WW'(head_addr);
	assign h_hi = h_lo + (WW'(1) << ord);

	// A block overlaps the request range, or is a candidate for allocation.
	assign hit.overlap = live && (h_lo < range_hi) && (range_lo < h_hi);
	assign hit.cand    = live && (ord >= need) && (ord <= ORD_W'(TOP_ORDER));
	assign hit.ord     = ord;

endmodule

// ===== src/bpa_ctrl.sv =====
module bpa_ctrl #(
	parameter int POOL_PAGES = bpa_pkg::POOL_PAGES_DEF,
	parameter int TOP_ORDER  = bpa_pkg::TOP_ORDER_DEF,
	localparam int AW = $clog2(POOL_PAGES),
	localparam int EW = $clog2(TOP_ORDER + 2),
	localparam int WA = (AW > TOP_ORDER) ? AW : TOP_ORDER,
	localparam int WW = ((WA > bpa_pkg::COUNT_W) ? WA : bpa_pkg::COUNT_W) + 2,
	localparam int TW = AW + 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	bpa_req_if.sink                   req,
	bpa_rsp_if.source                 rsp,
	output logic                      mem_we,
	output logic [AW-1:0]             mem_waddr,
	output logic [EW-1:0]             mem_wdata,
	output logic [AW-1:0]             mem_raddr,
	input  logic [EW-1:0]             mem_rdata,
	output logic [AW-1:0]             scan_addr,
	output logic [WW-1:0]             scan_lo,
	output logic [WW-1:0]             scan_hi,
	output logic [bpa_pkg::ORD_W-1:0] scan_need,
	input  bpa_pkg::scan_hit_t        scan_hit
);
	import bpa_pkg::*;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_CHECK,
		S_SCAN,
		S_REGION,
		S_TAKE,
		S_SPLIT,
		S_MRD,
		S_MCHK,
		S_MPUT,
		S_DONE
	} state_t;

	localparam logic [AW-1:0]    LAST_PAGE = AW'(POOL_PAGES - 1);
	localparam logic [WW-1:0]    POOL_END  = WW'(POOL_PAGES);
	localparam logic [ORD_W-1:0] TOP_ORD   = ORD_W'(TOP_ORDER);

	state_t             state_q;
	logic [MODE_W-1:0]  mode_q;
	logic [COUNT_W-1:0] cnt_q;
	logic [BASE_W-1:0]  base_q;
	logic [ORD_W-1:0]   need_q;
	logic [WW-1:0]      lo_q;
	logic [WW-1:0]      hi_q;
	logic [AW-1:0]      ra_q;
	logic               iss_q;
	logic               rd_vld_s1;
	logic [AW-1:0]      rd_addr_s1;
	logic               busy_q;
	logic               found_q;
	logic [ORD_W-1:0]   best_ord_q;
	logic [AW-1:0]      best_addr_q;
	logic [WW-1:0]      cur_b_q;
	logic [WW-1:0]      remain_q;
	logic [ORD_W-1:0]   o_q;
	logic [WW-1:0]      bud_q;
	logic [TW-1:0]      total_q;
	logic               res_status_q;
	logic [AW-1:0]      res_base_q;
	logic               rsp_vld_q;
	logic               rsp_status_q;
	logic [BASE_W-1:0]  rsp_base_q;
	logic [COUNT_W-1:0] rsp_total_q;

	logic [WW-1:0]      chk_len;
	logic [WW-1:0]      chk_hi;
	logic               chk_refuse;
	logic [ORD_W-1:0]   reg_ord;
	logic [WW-1:0]      reg_sz;
	logic [ORD_W-1:0]   split_ord;
	logic [WW-1:0]      split_addr;
	logic [WW-1:0]      bud;
	logic               merge_hit;
	logic [ORD_W-1:0]   t_ord;
	logic               t_add;
	logic [TW-1:0]      t_sz;
	logic [TW-1:0]      total_nx;

	// Largest block order that fits in v pages, capped at the top order.
	function automatic logic [ORD_W-1:0] fit_order(input logic [WW-1:0] v);
		int r;
		r = 0;
		for (int i = 0; i < WW; i++) begin
			if (v[i]) begin
				r = i;
			end
		end
		if (r > TOP_ORDER) begin
			r = TOP_ORDER;
		end
		return ORD_W'(r);
	endfunction

	// Early refusal: zero count, unknown kind, oversize order, or past the pool end.
	always_comb begin
		chk_len    = (mode_q == MODE_ADD) ? WW'(cnt_q) : (WW'(1) << need_q);
		chk_hi     = WW'(base_q) + chk_len;
		chk_refuse = (cnt_q == '0)
			|| ((mode_q != MODE_ADD) && (mode_q != MODE_ALLOC) && (mode_q != MODE_FREE))
			|| ((mode_q != MODE_ADD) && (need_q > TOP_ORD))
			|| ((mode_q != MODE_ALLOC) && (chk_hi > POOL_END));
	end

	// Step values for region carving, splitting and merging.
	always_comb begin
		reg_ord    = fit_order(remain_q);
		reg_sz     = WW'(1) << reg_ord;
		split_ord  = o_q - ORD_W'(1);
		split_addr = WW'(best_addr_q) + (WW'(1) << split_ord);
		bud        = cur_b_q ^ (WW'(1) << o_q);
		merge_hit  = (mem_rdata == (EW'(o_q) + EW'(1)));
	end

	// Shared add/subtract unit for the free-page total.
	always_comb begin
		t_ord = o_q;
		t_add = 1'b1;
		unique case (state_q)
			S_REGION: t_ord = reg_ord;
			S_TAKE: begin
				t_ord = best_ord_q;
				t_add = 1'b0;
			end
			S_SPLIT:  t_ord = split_ord;
			S_MCHK:   t_add = 1'b0;
			default: ;
		endcase
		t_sz     = TW'(1) << t_ord;
		total_nx = t_add ? (total_q + t_sz) : (total_q - t_sz);
	end

	// Memory port selection.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = ra_q;
		mem_wdata = '0;
		mem_raddr = ra_q;
		unique case (state_q)
			S_CLEAR:  mem_we = 1'b1;
			S_REGION: begin
				mem_we    = 1'b1;
				mem_waddr = cur_b_q[AW-1:0];
				mem_wdata = EW'(reg_ord) + EW'(1);
			end
			S_TAKE: begin
				mem_we    = 1'b1;
				mem_waddr = best_addr_q;
			end
			S_SPLIT: begin
				mem_we    = (o_q > need_q);
				mem_waddr = split_addr[AW-1:0];
				mem_wdata = EW'(split_ord) + EW'(1);
			end
			S_MRD:    mem_raddr = bud[AW-1:0];
			S_MCHK: begin
				mem_we    = merge_hit;
				mem_waddr = bud_q[AW-1:0];
			end
			S_MPUT: begin
				mem_we    = 1'b1;
				mem_waddr = cur_b_q[AW-1:0];
				mem_wdata = EW'(o_q) + EW'(1);
			end
			default: ;
		endcase
	end

	assign scan_addr = rd_addr_s1;
	assign scan_lo   = lo_q;
	assign scan_hi   = hi_q;
	assign scan_need = need_q;

	assign req.ready      = (state_q == S_IDLE);
	assign rsp.valid      = rsp_vld_q;
	assign rsp.status     = rsp_status_q;
	assign rsp.alloc_base = rsp_base_q;
	assign rsp.free_total = rsp_total_q;

	// Sequencer with its datapath registers and the response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			mode_q       <= '0;
			cnt_q        <= '0;
			base_q       <= '0;
			need_q       <= '0;
			lo_q         <= '0;
			hi_q         <= '0;
			ra_q         <= '0;
			iss_q        <= 1'b0;
			rd_vld_s1    <= 1'b0;
			rd_addr_s1   <= '0;
			busy_q       <= 1'b0;
			found_q      <= 1'b0;
			best_ord_q   <= '0;
			best_addr_q  <= '0;
			cur_b_q      <= '0;
			remain_q     <= '0;
			o_q          <= '0;
			bud_q        <= '0;
			total_q      <= '0;
			res_status_q <= STATUS_DONE;
			res_base_q   <= '0;
			rsp_vld_q    <= 1'b0;
			rsp_status_q <= STATUS_DONE;
			rsp_base_q   <= '0;
			rsp_total_q  <= '0;
		end else begin
			rd_vld_s1  <= (state_q == S_SCAN) && iss_q;
			rd_addr_s1 <= ra_q;

			// A taken response clears the register unless a new one is loaded now.
			if (rsp_vld_q && rsp.ready && (state_q != S_DONE)) begin
				rsp_vld_q <= 1'b0;
			end

			// Fold each returned head into the overlap flag and the best candidate.
			if ((state_q == S_SCAN) && rd_vld_s1) begin
				if (scan_hit.overlap) begin
					busy_q <= 1'b1;
				end
				if (scan_hit.cand && (!found_q || (scan_hit.ord < best_ord_q))) begin
					found_q     <= 1'b1;
					best_ord_q  <= scan_hit.ord;
					best_addr_q <= rd_addr_s1;
				end
			end

			unique case (state_q)
				S_CLEAR: begin
					if (ra_q == LAST_PAGE) begin
						ra_q    <= '0;
						state_q <= S_IDLE;
					end else begin
						ra_q <= ra_q + AW'(1);
					end
				end
				S_IDLE: begin
					if (req.valid) begin
						mode_q  <= req.mode;
						cnt_q   <= req.page_count;
						base_q  <= req.base_page;
						need_q  <= ceil_order(req.page_count);
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					lo_q <= WW'(base_q);
					hi_q <= chk_hi;
					if (chk_refuse) begin
						res_status_q <= STATUS_REFUSED;
						res_base_q   <= '0;
						state_q      <= S_DONE;
					end else begin
						ra_q    <= '0;
						iss_q   <= 1'b1;
						busy_q  <= 1'b0;
						found_q <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (iss_q) begin
						if (ra_q == LAST_PAGE) begin
							iss_q <= 1'b0;
						end else begin
							ra_q <= ra_q + AW'(1);
						end
					end else if (!rd_vld_s1) begin
						// The whole table has been seen: decide the request.
						res_status_q <= STATUS_REFUSED;
						res_base_q   <= '0;
						state_q      <= S_DONE;
						unique case (mode_q)
							MODE_ADD: begin
								if (!busy_q) begin
									cur_b_q  <= WW'(base_q);
									remain_q <= WW'(cnt_q);
									state_q  <= S_REGION;
								end
							end
							MODE_ALLOC: begin
								if (found_q) begin
									state_q <= S_TAKE;
								end
							end
							MODE_FREE: begin
								if (!busy_q) begin
									cur_b_q <= WW'(base_q);
									o_q     <= need_q;
									state_q <= S_MRD;
								end
							end
							default: ;
						endcase
					end
				end
				S_REGION: begin
					total_q  <= total_nx;
					cur_b_q  <= cur_b_q + reg_sz;
					remain_q <= remain_q - reg_sz;
					if (remain_q == reg_sz) begin
						res_status_q <= STATUS_DONE;
						res_base_q   <= '0;
						state_q      <= S_DONE;
					end
				end
				S_TAKE: begin
					total_q <= total_nx;
					o_q     <= best_ord_q;
					state_q <= S_SPLIT;
				end
				S_SPLIT: begin
					if (o_q > need_q) begin
						o_q     <= split_ord;
						total_q <= total_nx;
					end else begin
						res_status_q <= STATUS_DONE;
						res_base_q   <= best_addr_q;
						state_q      <= S_DONE;
					end
				end
				S_MRD: begin
					if ((o_q >= TOP_ORD) || (bud >= POOL_END)) begin
						state_q <= S_MPUT;
					end else begin
						bud_q   <= bud;
						state_q <= S_MCHK;
					end
				end
				S_MCHK: begin
					if (merge_hit) begin
						total_q <= total_nx;
						cur_b_q <= (bud_q < cur_b_q) ? bud_q : cur_b_q;
						o_q     <= o_q + ORD_W'(1);
						state_q <= S_MRD;
					end else begin
						state_q <= S_MPUT;
					end
				end
				S_MPUT: begin
					total_q      <= total_nx;
					res_status_q <= STATUS_DONE;
					res_base_q   <= '0;
					state_q      <= S_DONE;
				end
				S_DONE: begin
					if (!rsp_vld_q || rsp.ready) begin
						rsp_vld_q    <= 1'b1;
						rsp_status_q <= res_status_q;
						rsp_base_q   <= BASE_W'(res_base_q);
						rsp_total_q  <= COUNT_W'(total_q);
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== src/buddy_page_allocator.sv =====
// Channel  Role    Handshake    Item contents
// req      sink    valid/ready  mode, page_count, base_page
// rsp      source  valid/ready  status, alloc_base, free_total
//
// After reset a clearing pass writes every page entry, with req held off.
// A request refused on its fields alone goes straight to the response; any other first makes
// one full sweep of the page table through its single read port, then carves blocks on add,
// takes and splits a block on allocate, or merges buddies level by level on free until
// a buddy is not free or the top order or the pool end stops the merging.
// One request is in work at a time; the response register lets the next request be taken
// while the previous response still waits on rsp.ready.
module buddy_page_allocator #(
	parameter int POOL_PAGES = bpa_pkg::POOL_PAGES_DEF,
	parameter int TOP_ORDER  = bpa_pkg::TOP_ORDER_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	bpa_req_if.sink   req,
	bpa_rsp_if.source rsp
);
	import bpa_pkg::*;

	localparam int AW = $clog2(POOL_PAGES);
	localparam int EW = $clog2(TOP_ORDER + 2);
	localparam int WA = (AW > TOP_ORDER) ? AW : TOP_ORDER;
	localparam int WW = ((WA > COUNT_W) ? WA : COUNT_W) + 2;

	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	logic [EW-1:0]    mem_wdata;
	logic [AW-1:0]    mem_raddr;
	logic [EW-1:0]    mem_rdata;
	logic [AW-1:0]    scan_addr;
	logic [WW-1:0]    scan_lo;
	logic [WW-1:0]    scan_hi;
	logic [ORD_W-1:0] scan_need;
	scan_hit_t        scan_hit;

	// Sequencer, free-page total and response register.
	bpa_ctrl #(
		.POOL_PAGES(POOL_PAGES),
		.TOP_ORDER (TOP_ORDER)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rsp      (rsp),
		.mem_we   (mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata),
		.scan_addr(scan_addr),
		.scan_lo  (scan_lo),
		.scan_hi  (scan_hi),
		.scan_need(scan_need),
		.scan_hit (scan_hit)
	);

	// Page table: one block-head code per page.
	bpa_page_mem #(
		.POOL_PAGES(POOL_PAGES),
		.TOP_ORDER (TOP_ORDER)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// Compare unit applied to each head as the sweep returns it.
	bpa_scan_unit #(
		.POOL_PAGES(POOL_PAGES),
		.TOP_ORDER (TOP_ORDER)
	) u_scan (
		.head_addr(scan_addr),
		.head_code(mem_rdata),
		.range_lo (scan_lo),
		.range_hi (scan_hi),
		.need     (scan_need),
		.hit      (scan_hit)
	);

endmodule
